[src/pfrgb_pkg.sv]
// Shared types, constants and helpers for the pixel format converter.
package pfrgb_pkg;

   localparam int unsigned NUM_SEPARATIONS_DEFAULT = 8;
   localparam int unsigned MAX_SEPARATIONS = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH = 8;

   localparam logic [1:0] CSR_SOURCE_MODE  = 2'd0;
   localparam logic [1:0] CSR_VISIBLE_MASK = 2'd1;
   localparam logic [1:0] CSR_USED_MASK    = 2'd2;
   localparam logic [1:0] CSR_GRAY_SINGLE  = 2'd3;

   localparam logic [3:0] MODE_BGR555LE = 4'd0;
   localparam logic [3:0] MODE_BGR565LE = 4'd1;
   localparam logic [3:0] MODE_RGB555BE = 4'd2;
   localparam logic [3:0] MODE_RGB565BE = 4'd3;
   localparam logic [3:0] MODE_XRGB     = 4'd4;
   localparam logic [3:0] MODE_BGRX     = 4'd5;
   localparam logic [3:0] MODE_XBGR     = 4'd6;
   localparam logic [3:0] MODE_BGR24    = 4'd7;
   localparam logic [3:0] MODE_CMYK8    = 4'd8;
   localparam logic [3:0] MODE_CMYK1    = 4'd9;
   localparam logic [3:0] MODE_SEPS     = 4'd10;

   localparam logic [3:0]  RESET_SOURCE_MODE  = MODE_BGR555LE;
   localparam logic [7:0]  RESET_VISIBLE_MASK = 8'hff;
   localparam logic [7:0]  RESET_USED_MASK    = 8'h0f;
   localparam logic        RESET_GRAY_SINGLE  = 1'b0;
   localparam logic [16:0] WEIGHT_SCALE       = 17'd65535;
   localparam logic [7:0]  FULL_INK           = 8'd255;

   typedef struct packed {
      logic        command;
      logic [63:0] pixel_bytes;
      logic [2:0]  entry_index;
      logic [15:0] cyan_weight;
      logic [15:0] magenta_weight;
      logic [15:0] yellow_weight;
      logic [15:0] black_weight;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   // floor(x / 65535) for x < 256 * 65535: q = (x + (x >> 16) + 1) >> 16
   function automatic logic [7:0] div65535(input logic [23:0] x);
      logic [24:0] t;
      t = {1'b0, x} + {17'd0, x[23:16]} + 25'd1;
      return t[23:16];
   endfunction

   // floor(x / 255) for x < 256 * 255
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

[src/pixel_format_to_rgb24_converter_core.sv]
// Pixel format converter: source pixels to 8-bit red, green and blue.
//
// Requests enter on req_valid/req_ready with a req_type payload; results
// leave on rsp_valid/rsp_ready with a rsp_type payload. A request with
// command set loads one colorant entry and gives no result; every other
// request gives exactly one result.
// The datapath is a five-stage pipeline: select and mask, per-channel
// weight products, quotient sum and clamp, ink product, divide by 255.
// An accepted request passes the stage 1 to 4 registers and the output
// register before it shows on rsp_valid; one request per cycle is
// sustained while rsp_ready is high.
// The csr_ port writes source_mode, visible_mask, used_mask and gray_single
// by index; write only while the pipeline is empty.
// Reset clears the pipeline, sets the registers to their defaults and
// clears the colorant table.
// When the receiver stalls, the whole pipeline holds; req_ready falls and
// nothing is lost or repeated.
module pixel_format_to_rgb24_converter_core #(
   parameter int unsigned NUM_SEPARATIONS = pfrgb_pkg::NUM_SEPARATIONS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  pfrgb_pkg::req_type                     req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output pfrgb_pkg::rsp_type                     rsp_payload,
   input  logic                                   csr_write_enable,
   input  logic [pfrgb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pfrgb_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);

   localparam int unsigned NS = NUM_SEPARATIONS;

   logic [3:0] source_mode_ff;
   logic [7:0] visible_mask_ff, used_mask_ff;
   logic       gray_single_ff;
   logic [63:0] colorant_table_ff [NS];

   logic advance;
   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_mode_ff <= pfrgb_pkg::RESET_SOURCE_MODE;
         visible_mask_ff <= pfrgb_pkg::RESET_VISIBLE_MASK;
         used_mask_ff <= pfrgb_pkg::RESET_USED_MASK;
         gray_single_ff <= pfrgb_pkg::RESET_GRAY_SINGLE;
      end else if (csr_write_enable) begin
         case (csr_index)
            pfrgb_pkg::CSR_SOURCE_MODE: source_mode_ff <= csr_write_data[3:0];
            pfrgb_pkg::CSR_VISIBLE_MASK: visible_mask_ff <= csr_write_data;
            pfrgb_pkg::CSR_USED_MASK: used_mask_ff <= csr_write_data;
            pfrgb_pkg::CSR_GRAY_SINGLE: gray_single_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Stage 1: decode, direct formats, ink selection
   logic req_accept;
   assign req_accept = req_valid && advance;

   logic        s1_valid_ff;
   logic        s1_direct_ff, s1_sep_ff, s1_gray_ff;
   logic [23:0] s1_rgb_ff;
   logic [7:0]  s1_ink_ff [4];
   logic [7:0]  s1_byte_ff [NS];
   logic [NS-1:0] s1_on_ff;

   logic [15:0] w16;
   logic [23:0] rgb_in;
   logic        direct_in, sep_in, gray_in;
   logic [7:0]  ink_in [4];
   logic [NS-1:0] on_in;
   logic [3:0]  nvis;
   logic [7:0]  px [8];

   always_comb begin
      for (int i = 0; i < 8; i++) px[i] = req_payload.pixel_bytes[8*i +: 8];
      on_in = visible_mask_ff[NS-1:0] & used_mask_ff[NS-1:0];
      w16 = 16'd0;
      rgb_in = 24'd0;
      direct_in = 1'b1;
      sep_in = 1'b0;
      gray_in = 1'b0;
      nvis = 4'd0;
      for (int j = 0; j < 4; j++) ink_in[j] = 8'd0;
      case (source_mode_ff)
         pfrgb_pkg::MODE_BGR555LE, pfrgb_pkg::MODE_BGR565LE: w16 = {px[1], px[0]};
         pfrgb_pkg::MODE_RGB555BE, pfrgb_pkg::MODE_RGB565BE: w16 = {px[0], px[1]};
         default: w16 = 16'd0;
      endcase
      case (source_mode_ff)
         pfrgb_pkg::MODE_BGR555LE, pfrgb_pkg::MODE_RGB555BE:
            rgb_in = {pfrgb_pkg::widen5(w16[14:10]), pfrgb_pkg::widen5(w16[9:5]),
                      pfrgb_pkg::widen5(w16[4:0])};
         pfrgb_pkg::MODE_BGR565LE, pfrgb_pkg::MODE_RGB565BE:
            rgb_in = {pfrgb_pkg::widen5(w16[15:11]), pfrgb_pkg::widen6(w16[10:5]),
                      pfrgb_pkg::widen5(w16[4:0])};
         pfrgb_pkg::MODE_XRGB: rgb_in = {px[1], px[2], px[3]};
         pfrgb_pkg::MODE_BGRX, pfrgb_pkg::MODE_BGR24: rgb_in = {px[2], px[1], px[0]};
         pfrgb_pkg::MODE_XBGR: rgb_in = {px[3], px[2], px[1]};
         pfrgb_pkg::MODE_CMYK8, pfrgb_pkg::MODE_CMYK1: begin
            direct_in = 1'b0;
            for (int j = 0; j < 4; j++) begin
               if (source_mode_ff == pfrgb_pkg::MODE_CMYK8) ink_in[j] = px[j];
               else ink_in[j] = {8{req_payload.pixel_bytes[3-j]}};
               if (visible_mask_ff[j]) nvis = nvis + 4'd1;
               else ink_in[j] = 8'd0;
            end
            // visible inks other than the one are zero, so OR gives the sum
            if (nvis == 4'd1 && gray_single_ff) begin
               ink_in[3] = ink_in[0] | ink_in[1] | ink_in[2] | ink_in[3];
               ink_in[0] = 8'd0;
               ink_in[1] = 8'd0;
               ink_in[2] = 8'd0;
            end
         end
         pfrgb_pkg::MODE_SEPS: begin
            direct_in = 1'b0;
            sep_in = 1'b1;
            for (int j = 0; j < NS; j++) nvis = nvis + {3'd0, on_in[j]};
            gray_in = (nvis == 4'd1) && gray_single_ff;
         end
         default: rgb_in = 24'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NS; j++) colorant_table_ff[j] <= 64'd0;
      end else if (req_accept && req_payload.command &&
                   {29'd0, req_payload.entry_index} < NS) begin
         colorant_table_ff[req_payload.entry_index[$clog2(NS)-1:0]] <=
            {req_payload.black_weight, req_payload.yellow_weight,
             req_payload.magenta_weight, req_payload.cyan_weight};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (advance) s1_valid_ff <= req_valid && !req_payload.command;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_direct_ff <= direct_in;
         s1_sep_ff <= sep_in;
         s1_gray_ff <= gray_in;
         s1_rgb_ff <= rgb_in;
         s1_on_ff <= on_in;
         for (int j = 0; j < 4; j++) s1_ink_ff[j] <= ink_in[j];
         for (int j = 0; j < NS; j++) s1_byte_ff[j] <= px[j];
      end
   end

   // Stage 2: byte times weight for every separation and ink
   logic        s2_valid_ff, s2_direct_ff, s2_sep_ff, s2_gray_ff;
   logic [23:0] s2_rgb_ff;
   logic [7:0]  s2_ink_ff [4];
   logic [23:0] s2_prod_ff [NS][4];
   logic [7:0]  s2_gray_byte_ff;
   logic [7:0]  gray_byte;

   always_comb begin
      gray_byte = 8'd0;
      for (int j = 0; j < NS; j++) if (s1_on_ff[j]) gray_byte = gray_byte | s1_byte_ff[j];
   end

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else if (advance) s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_direct_ff <= s1_direct_ff;
         s2_sep_ff <= s1_sep_ff;
         s2_gray_ff <= s1_gray_ff;
         s2_rgb_ff <= s1_rgb_ff;
         s2_gray_byte_ff <= gray_byte;
         for (int j = 0; j < 4; j++) s2_ink_ff[j] <= s1_ink_ff[j];
         for (int j = 0; j < NS; j++)
            for (int q = 0; q < 4; q++)
               s2_prod_ff[j][q] <= s1_on_ff[j]
                  ? {16'd0, s1_byte_ff[j]} * colorant_table_ff[j][16*q +: 16] : 24'd0;
      end
   end

   // Stage 3: quotients summed, clamp, ink selection
   logic        s3_valid_ff, s3_direct_ff;
   logic [23:0] s3_rgb_ff;
   logic [7:0]  s3_ink_ff [4];
   logic [11:0] sum [4];
   logic [7:0]  ink3 [4];

   always_comb begin
      for (int q = 0; q < 4; q++) begin
         sum[q] = 12'd0;
         for (int j = 0; j < NS; j++)
            sum[q] = sum[q] + {4'd0, pfrgb_pkg::div65535(s2_prod_ff[j][q])};
         if (!s2_sep_ff) ink3[q] = s2_ink_ff[q];
         else if (s2_gray_ff) ink3[q] = (q == 3) ? s2_gray_byte_ff : 8'd0;
         else ink3[q] = (sum[q] > 12'd255) ? pfrgb_pkg::FULL_INK : sum[q][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else if (advance) s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_direct_ff <= s2_direct_ff;
         s3_rgb_ff <= s2_rgb_ff;
         for (int q = 0; q < 4; q++) s3_ink_ff[q] <= ink3[q];
      end
   end

   // Stage 4: complement products
   logic        s4_valid_ff, s4_direct_ff;
   logic [23:0] s4_rgb_ff;
   logic [15:0] s4_prod_ff [3];
   logic [7:0]  kc;
   assign kc = pfrgb_pkg::FULL_INK - s3_ink_ff[3];

   always_ff @(posedge clock) begin
      if (reset) s4_valid_ff <= 1'b0;
      else if (advance) s4_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_direct_ff <= s3_direct_ff;
         s4_rgb_ff <= s3_rgb_ff;
         for (int q = 0; q < 3; q++)
            s4_prod_ff[q] <= {8'd0, pfrgb_pkg::FULL_INK - s3_ink_ff[q]} * {8'd0, kc};
      end
   end

   // Stage 5: divide by 255, output register
   logic    rsp_valid_ff;
   pfrgb_pkg::rsp_type rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= s4_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (s4_direct_ff) rsp_payload_ff <= s4_rgb_ff;
         else rsp_payload_ff <= {pfrgb_pkg::div255(s4_prod_ff[0]),
                                 pfrgb_pkg::div255(s4_prod_ff[1]),
                                 pfrgb_pkg::div255(s4_prod_ff[2])};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
